### rtl/core/trial_division_prime_counter_top_assert.svh
// Assertion macros for the prime counter top level
`ifndef TRIAL_DIVISION_PRIME_COUNTER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define TDPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tdpc assertion failed");

// next-cycle implication, held off while reset is asserted
`define TDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tdpc assertion failed");

`endif

### rtl/core/tdpc_pkg.sv
// Shared constants, payload types and control structs for the prime counter
package tdpc_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int FIELD_W   = 32;
	localparam int COUNT_W   = 32;
	// trial divisor stays below 2^(NUM_WIDTH/2)+2, its square below 2^(NUM_WIDTH+2)
	localparam int DIV_W     = NUM_WIDTH / 2 + 2;
	localparam int SQ_W      = NUM_WIDTH + 2;
	localparam int BIT_W     = $clog2(NUM_WIDTH);

	typedef struct packed {
		logic [FIELD_W-1:0] number;
		logic               first_of_run;
	} req_t;

	typedef struct packed {
		logic               is_prime;
		logic [COUNT_W-1:0] prime_total;
		logic [COUNT_W-1:0] composite_total;
	} res_t;

	typedef struct packed {
		logic load;       // capture a new request
		logic div_start;  // clear remainder, load dividend shifter
		logic div_step;   // one restoring remainder bit
		logic next_div;   // advance divisor by two, update its square
		logic finish;     // count and publish the verdict
		logic prime;      // verdict that goes with finish
	} cmd_t;

	typedef struct packed {
		logic small_prime; // number is two or three
		logic small_comp;  // number below two, or even
		logic sq_over;     // divisor squared exceeds the number
		logic div_last;    // current remainder step is the last one
		logic rem_zero;    // divisor leaves no remainder
		logic out_full;    // result register holds a stalled result
	} stat_t;

endpackage

### rtl/core/tdpc_datapath.sv
// Datapath: operand registers, bit-serial remainder unit, counters and result register
module tdpc_datapath import tdpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] sh_q;
	logic                 first_q;
	logic [DIV_W-1:0]     d_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DIV_W-1:0]     rem_q;
	logic [BIT_W-1:0]     bit_q;
	logic [COUNT_W-1:0]   prime_cnt_q;
	logic [COUNT_W-1:0]   comp_cnt_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic [DIV_W:0]       shifted;
	logic [DIV_W-1:0]     rem_next;
	logic [COUNT_W-1:0]   prime_base;
	logic [COUNT_W-1:0]   comp_base;
	logic [COUNT_W-1:0]   prime_new;
	logic [COUNT_W-1:0]   comp_new;

	assign shifted  = {rem_q, sh_q[NUM_WIDTH-1]};
	assign rem_next = (shifted >= {1'b0, d_q}) ? DIV_W'(shifted - {1'b0, d_q})
	                                           : shifted[DIV_W-1:0];

	assign stat.small_prime = (n_q == NUM_WIDTH'(2)) || (n_q == NUM_WIDTH'(3));
	assign stat.small_comp  = (n_q < NUM_WIDTH'(2)) || !n_q[0];
	assign stat.sq_over     = sq_q > {2'b00, n_q};
	assign stat.div_last    = bit_q == BIT_W'(NUM_WIDTH - 1);
	assign stat.rem_zero    = rem_q == '0;
	assign stat.out_full    = res_valid_q && res_stall;

	assign prime_base = first_q ? '0 : prime_cnt_q;
	assign comp_base  = first_q ? '0 : comp_cnt_q;
	assign prime_new  = (cmd.prime && !(&prime_base)) ? prime_base + COUNT_W'(1) : prime_base;
	assign comp_new   = (!cmd.prime && !(&comp_base)) ? comp_base + COUNT_W'(1) : comp_base;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= req.number[NUM_WIDTH-1:0];
			first_q <= req.first_of_run;
			d_q     <= DIV_W'(3);
			sq_q    <= SQ_W'(9);
		end else if (cmd.next_div) begin
			d_q  <= d_q + DIV_W'(2);
			// (d+2)^2 = d^2 + 4d + 4
			sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
		end
		if (cmd.div_start) begin
			sh_q  <= n_q;
			rem_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			sh_q  <= {sh_q[NUM_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
			bit_q <= bit_q + BIT_W'(1);
		end
		if (cmd.finish) begin
			res_q.is_prime        <= cmd.prime;
			res_q.prime_total     <= prime_new;
			res_q.composite_total <= comp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_cnt_q <= '0;
			comp_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				prime_cnt_q <= prime_new;
				comp_cnt_q  <= comp_new;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/tdpc_ctrl.sv
// Controller: sequences classification, divisor loop and result hand-off
module tdpc_ctrl import tdpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CLASSIFY = 3'd1;
	localparam logic [2:0] S_CHECK    = 3'd2;
	localparam logic [2:0] S_DIV      = 3'd3;
	localparam logic [2:0] S_TEST     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       verdict_q;
	logic       verdict_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d   = state_q;
		verdict_d = verdict_q;
		cmd       = '0;
		cmd.prime = verdict_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				if (stat.small_prime) begin
					verdict_d = 1'b1;
					state_d   = S_DONE;
				end else if (stat.small_comp) begin
					verdict_d = 1'b0;
					state_d   = S_DONE;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.sq_over) begin
					verdict_d = 1'b1;
					state_d   = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.rem_zero) begin
					verdict_d = 1'b0;
					state_d   = S_DONE;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_DONE: begin
				// wait for the result register to free up
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			verdict_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			verdict_q <= verdict_d;
		end
	end

endmodule

### rtl/core/trial_division_prime_counter_top.sv
// Top level of the trial division prime counter
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   req     | in        | req_valid / req_stall  | number, first_of_run
//   res     | out       | res_valid / res_stall  | is_prime, prime_total, composite_total
//
// One request at a time. Numbers below four and even numbers are settled without trial division.
// Each odd trial divisor takes a bound check, a bit-serial remainder at one bit per
// cycle and a zero test. The result register frees the input side once a verdict
// is published, so a new request is taken while a result waits on res_stall.
// Reset clears both counts and the control state; no clearing pass.
module trial_division_prime_counter_top import tdpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	`include "trial_division_prime_counter_top_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	tdpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tdpc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	`TDPC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)
	`TDPC_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.finish, !(res_valid && res_stall))
	`TDPC_ASSERT_NOW(a_prime_counted, clk, arst_n, res_valid && res.is_prime, res.prime_total != '0)

endmodule
